FILE: design/wcpe_pkg.sv
`default_nettype none

package wcpe_pkg;

  // Queue between the front and the back part.
  localparam int unsigned QUEUE_AW    = 2;
  localparam int unsigned QUEUE_DEPTH = 1 << QUEUE_AW;

  // Iterations of the restoring divider (45-bit dividend).
  localparam logic [5:0] DIV_STEPS = 6'd45;

  // Display limits and per-sample closing limit.
  localparam logic [12:0] MAX_COLUMNS = 13'd4096;
  localparam logic [6:0]  STEP_LIMIT  = 7'd64;

  // ceil(2^22 / 25), exact for quotients of values below 2^17 by 25.
  localparam logic [17:0] HEIGHT_RECIP = 18'd167773;

  // Configuration register indexes.
  localparam logic [1:0] CFG_VISIBLE_FRAMES = 2'd0;
  localparam logic [1:0] CFG_COLUMN_COUNT   = 2'd1;
  localparam logic [1:0] CFG_CANVAS_HEIGHT  = 2'd2;

  // Register reset values.
  localparam logic [31:0] VISIBLE_FRAMES_RST = 32'd65536;
  localparam logic [12:0] COLUMN_COUNT_RST   = 13'd1024;
  localparam logic [12:0] CANVAS_HEIGHT_RST  = 13'd256;

  // Values of an empty column.
  localparam logic signed [15:0] EMPTY_MIN = 16'sh7FFF;
  localparam logic signed [15:0] EMPTY_MAX = -16'sh8000;

  typedef enum logic {
    KIND_START  = 1'b0,
    KIND_SAMPLE = 1'b1
  } item_kind_e;

  typedef struct packed {
    logic              cmd;
    logic signed [15:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [11:0]        column;
    logic signed [15:0] column_min;
    logic signed [15:0] column_max;
    logic [11:0]        top_pixel;
    logic [11:0]        bottom_pixel;
    logic               last_of_item;
  } out_item_t;

  typedef struct packed {
    item_kind_e         kind;
    logic signed [15:0] sample;
  } queue_entry_t;

  // Register view handed to the back part; width is already clamped.
  typedef struct packed {
    logic [31:0] visible_frames;
    logic [12:0] width;
    logic [12:0] height;
    logic        geo_dirty;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [44:0] dividend;
    logic [12:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [44:0] quotient;
    logic [11:0] remainder;
  } div_rsp_t;

  // Sample times height times 11, the numerator of the pixel offset.
  function automatic logic signed [33:0] pix_scaled(logic signed [15:0] s,
                                                    logic [12:0] h);
    logic signed [29:0] sh;
    logic signed [33:0] e;
    sh = 30'(s) * 30'($signed({1'b0, h}));
    e  = 34'(sh);
    return (e <<< 3) + (e <<< 1) + e;
  endfunction

  // Magnitude of the offset: floor(|p| / 819200) = floor((|p| >> 15) / 25).
  function automatic logic [11:0] pix_offset(logic signed [33:0] p);
    logic [33:0] mag;
    logic [16:0] a;
    logic [34:0] prod;
    mag  = p[33] ? 34'(-p) : 34'(p);
    a    = mag[31:15];
    prod = 35'(a) * 35'(HEIGHT_RECIP);
    return prod[33:22];
  endfunction

  // Pixel row: centre minus signed offset, saturated to 0..4095.
  function automatic logic [11:0] pix_row(logic [12:0] h, logic [11:0] q, logic neg);
    logic signed [14:0] c;
    logic signed [14:0] row;
    c   = $signed({3'b000, h[12:1]});
    row = neg ? (c + $signed({3'b000, q})) : (c - $signed({3'b000, q}));
    if (row < 15'sd0) begin
      return 12'd0;
    end else if (row > 15'sd4095) begin
      return 12'd4095;
    end else begin
      return row[11:0];
    end
  endfunction

endpackage

`default_nettype wire

FILE: design/wcpe_front.sv
`default_nettype none

module wcpe_front (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire wcpe_pkg::in_item_t      in_data_i,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [1:0]              cfg_index_i,
  input  wire logic [31:0]             cfg_data_i,
  input  wire logic                    q_full_i,
  output logic                         q_push_o,
  output wcpe_pkg::queue_entry_t       q_entry_o,
  input  wire logic                    geo_clear_i,
  output wcpe_pkg::cfg_t               cfg_o
);
  import wcpe_pkg::*;

  logic [31:0] vf_q;
  logic [12:0] cc_q;
  logic [12:0] ch_q;
  logic        dirty_q;
  logic        cfg_wr;

  // Accept requests while the queue has room and tag each by its kind.
  assign in_stall_o       = q_full_i;
  assign q_push_o         = in_valid_i && !q_full_i;
  assign q_entry_o.kind   = in_data_i.cmd ? KIND_SAMPLE : KIND_START;
  assign q_entry_o.sample = in_data_i.sample;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  // Register file. A change of frames or width marks the column geometry stale.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q    <= VISIBLE_FRAMES_RST;
      cc_q    <= COLUMN_COUNT_RST;
      ch_q    <= CANVAS_HEIGHT_RST;
      dirty_q <= 1'b1;
    end else begin
      if (geo_clear_i) begin
        dirty_q <= 1'b0;
      end
      if (cfg_wr) begin
        case (cfg_index_i)
          CFG_VISIBLE_FRAMES: begin
            vf_q    <= cfg_data_i;
            dirty_q <= 1'b1;
          end
          CFG_COLUMN_COUNT: begin
            cc_q    <= cfg_data_i[12:0];
            dirty_q <= 1'b1;
          end
          CFG_CANVAS_HEIGHT: begin
            ch_q <= cfg_data_i[12:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign cfg_o.visible_frames = vf_q;
  assign cfg_o.width          = (cc_q > MAX_COLUMNS) ? MAX_COLUMNS : cc_q;
  assign cfg_o.height         = ch_q;
  assign cfg_o.geo_dirty      = dirty_q;

endmodule

`default_nettype wire

FILE: design/wcpe_queue.sv
`default_nettype none

module wcpe_queue (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire wcpe_pkg::queue_entry_t entry_i,
  output logic                        full_o,
  input  wire logic                   pop_i,
  output wcpe_pkg::queue_entry_t      head_o,
  output logic                        empty_o
);
  import wcpe_pkg::*;

  queue_entry_t            mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]     wr_ptr_q;
  logic [QUEUE_AW-1:0]     rd_ptr_q;
  logic [QUEUE_AW:0]       count_q;

  assign full_o  = (count_q == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Storage for queued requests.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/wcpe_div.sv
`default_nettype none

module wcpe_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire wcpe_pkg::div_req_t req_i,
  output wcpe_pkg::div_rsp_t      rsp_o
);
  import wcpe_pkg::*;

  logic        busy_q;
  logic        done_q;
  logic [5:0]  cnt_q;
  logic [44:0] dvd_q;
  logic [11:0] rem_q;
  logic [12:0] divisor_q;
  logic [12:0] trial;
  logic        fits;
  logic [12:0] trial_sub;

  // One quotient bit per cycle, restoring form.
  assign trial     = {rem_q, dvd_q[44]};
  assign fits      = (trial >= divisor_q);
  assign trial_sub = trial - divisor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      done_q    <= 1'b0;
      cnt_q     <= '0;
      dvd_q     <= '0;
      rem_q     <= '0;
      divisor_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q    <= 1'b1;
        cnt_q     <= DIV_STEPS;
        dvd_q     <= req_i.dividend;
        rem_q     <= '0;
        divisor_q <= req_i.divisor;
      end else if (busy_q) begin
        dvd_q <= {dvd_q[43:0], fits};
        rem_q <= fits ? trial_sub[11:0] : trial[11:0];
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = dvd_q;
  assign rsp_o.remainder = rem_q;

endmodule

`default_nettype wire

FILE: design/wcpe_back.sv
`default_nettype none

module wcpe_back (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire wcpe_pkg::cfg_t         cfg_i,
  output logic                        geo_clear_o,
  input  wire logic                   q_empty_i,
  input  wire wcpe_pkg::queue_entry_t q_head_i,
  output logic                        q_pop_o,
  output wcpe_pkg::div_req_t          div_req_o,
  input  wire wcpe_pkg::div_rsp_t     div_rsp_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output wcpe_pkg::out_item_t         out_data_o
);
  import wcpe_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE,
    B_CHECK,
    B_DIVA,
    B_DIVB,
    B_SHIFT1,
    B_SHIFT2,
    B_TEST,
    B_PIX1,
    B_PIX2,
    B_PIX3
  } back_state_e;

  back_state_e        state_q;
  item_kind_e         kind_q;
  logic signed [15:0] s_q;
  logic [12:0]        x_q;
  logic [31:0]        f_q;
  logic [6:0]         n_q;
  logic signed [15:0] run_min_q;
  logic signed [15:0] run_max_q;
  // Column bounds: first(x), first(x+1), first(x+2) with the remainder of the last.
  logic [31:0]        p0q_q;
  logic [31:0]        p1q_q;
  logic [31:0]        p2q_q;
  logic [11:0]        p2r_q;
  // Per-column increment V / W.
  logic [31:0]        stepq_q;
  logic [11:0]        stepr_q;
  logic [44:0]        vx_q;
  // Column being reported.
  logic [11:0]        col_q;
  logic signed [15:0] cmin_q;
  logic signed [15:0] cmax_q;
  logic               last_q;
  logic signed [33:0] prod_min_q;
  logic signed [33:0] prod_max_q;
  logic [11:0]        off_min_q;
  logic [11:0]        off_max_q;
  logic               neg_min_q;
  logic               neg_max_q;
  logic               out_valid_q;
  out_item_t          out_q;
  div_req_t           div_req_q;
  logic               geo_clear_q;

  logic        w_nz;
  logic [32:0] f_inc;
  logic [32:0] last0;
  logic [32:0] last1;
  logic        close0;
  logic        close1;
  logic [12:0] x_inc;
  logic [6:0]  n_inc;
  logic        more;
  logic        shared;
  logic [12:0] r_sum;
  logic        r_wrap;
  logic [12:0] r_fix;
  logic [11:0] p2r_next;
  logic [31:0] p2q_next;
  logic [44:0] vx_prod;
  logic        out_free;

  assign w_nz   = (cfg_i.width != '0);
  assign f_inc  = {1'b0, f_q} + 33'd1;
  assign x_inc  = x_q + 13'd1;
  assign n_inc  = n_q + 7'd1;

  // Column end, at least one frame past its start, for this and the next column.
  assign last0  = ({1'b0, p1q_q} > ({1'b0, p0q_q} + 33'd1)) ? {1'b0, p1q_q}
                                                             : ({1'b0, p0q_q} + 33'd1);
  assign last1  = ({1'b0, p2q_q} > ({1'b0, p1q_q} + 33'd1)) ? {1'b0, p2q_q}
                                                             : ({1'b0, p1q_q} + 33'd1);
  assign close0 = (f_inc >= last0);
  assign close1 = (f_inc >= last1);
  assign more   = (n_inc < STEP_LIMIT) && (x_inc < cfg_i.width) && close1;
  // The next column already starts at this frame.
  assign shared = (x_inc < cfg_i.width) && (p1q_q <= f_q);

  // Advance the lookahead bound by V / W with remainder carry.
  assign r_sum    = {1'b0, p2r_q} + {1'b0, stepr_q};
  assign r_wrap   = (r_sum >= cfg_i.width);
  assign r_fix    = r_wrap ? (r_sum - cfg_i.width) : r_sum;
  assign p2r_next = r_fix[11:0];
  assign p2q_next = p2q_q + stepq_q + {31'd0, r_wrap};

  assign vx_prod  = 45'(cfg_i.visible_frames) * 45'(x_q);
  assign out_free = !out_valid_q || !out_stall_i;

  assign q_pop_o     = (state_q == B_IDLE) && !q_empty_i;
  assign geo_clear_o = geo_clear_q;
  assign div_req_o   = div_req_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Column engine.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      kind_q      <= KIND_START;
      s_q         <= '0;
      x_q         <= '0;
      f_q         <= '0;
      n_q         <= '0;
      run_min_q   <= EMPTY_MIN;
      run_max_q   <= EMPTY_MAX;
      p0q_q       <= '0;
      p1q_q       <= '0;
      p2q_q       <= '0;
      p2r_q       <= '0;
      stepq_q     <= '0;
      stepr_q     <= '0;
      vx_q        <= '0;
      col_q       <= '0;
      cmin_q      <= '0;
      cmax_q      <= '0;
      last_q      <= 1'b0;
      prod_min_q  <= '0;
      prod_max_q  <= '0;
      off_min_q   <= '0;
      off_max_q   <= '0;
      neg_min_q   <= 1'b0;
      neg_max_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      div_req_q   <= '0;
      geo_clear_q <= 1'b0;
    end else begin
      div_req_q.start <= 1'b0;
      geo_clear_q     <= 1'b0;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        // Take the next request from the queue.
        B_IDLE: begin
          if (!q_empty_i) begin
            kind_q <= q_head_i.kind;
            s_q    <= q_head_i.sample;
            if (q_head_i.kind == KIND_START) begin
              x_q       <= '0;
              f_q       <= '0;
              run_min_q <= EMPTY_MIN;
              run_max_q <= EMPTY_MAX;
              p2q_q     <= '0;
              p2r_q     <= '0;
              if (cfg_i.geo_dirty && w_nz) begin
                vx_q      <= '0;
                div_req_q <= '{start: 1'b1,
                               dividend: 45'(cfg_i.visible_frames),
                               divisor: cfg_i.width};
                state_q   <= B_DIVA;
              end else begin
                state_q <= B_SHIFT1;
              end
            end else begin
              state_q <= B_CHECK;
            end
          end
        end

        // Skip finished sweeps, refresh stale bounds, fold the sample in.
        B_CHECK: begin
          if (!w_nz || (x_q >= cfg_i.width)) begin
            state_q <= B_IDLE;
          end else if (cfg_i.geo_dirty) begin
            vx_q      <= vx_prod;
            div_req_q <= '{start: 1'b1,
                           dividend: 45'(cfg_i.visible_frames),
                           divisor: cfg_i.width};
            state_q   <= B_DIVA;
          end else begin
            if (s_q < run_min_q) begin
              run_min_q <= s_q;
            end
            if (s_q > run_max_q) begin
              run_max_q <= s_q;
            end
            n_q     <= '0;
            state_q <= B_TEST;
          end
        end

        // V / W gives the per-column step.
        B_DIVA: begin
          if (div_rsp_i.done) begin
            stepq_q   <= div_rsp_i.quotient[31:0];
            stepr_q   <= div_rsp_i.remainder;
            div_req_q <= '{start: 1'b1, dividend: vx_q, divisor: cfg_i.width};
            state_q   <= B_DIVB;
          end
        end

        // V * x / W gives the start of the current column.
        B_DIVB: begin
          if (div_rsp_i.done) begin
            p2q_q       <= div_rsp_i.quotient[31:0];
            p2r_q       <= div_rsp_i.remainder;
            geo_clear_q <= 1'b1;
            state_q     <= B_SHIFT1;
          end
        end

        // Two advances fill the bound registers from the seed.
        B_SHIFT1: begin
          p0q_q   <= p1q_q;
          p1q_q   <= p2q_q;
          p2q_q   <= p2q_next;
          p2r_q   <= p2r_next;
          state_q <= B_SHIFT2;
        end

        B_SHIFT2: begin
          p0q_q   <= p1q_q;
          p1q_q   <= p2q_q;
          p2q_q   <= p2q_next;
          p2r_q   <= p2r_next;
          state_q <= (kind_q == KIND_SAMPLE) ? B_CHECK : B_IDLE;
        end

        // Close the current column if this frame ends it.
        B_TEST: begin
          if (!close0) begin
            f_q     <= f_inc[31:0];
            state_q <= B_IDLE;
          end else begin
            col_q   <= x_q[11:0];
            cmin_q  <= run_min_q;
            cmax_q  <= run_max_q;
            last_q  <= !more;
            x_q     <= x_inc;
            n_q     <= n_inc;
            p0q_q   <= p1q_q;
            p1q_q   <= p2q_q;
            p2q_q   <= p2q_next;
            p2r_q   <= p2r_next;
            if (shared) begin
              run_min_q <= s_q;
              run_max_q <= s_q;
            end else begin
              run_min_q <= EMPTY_MIN;
              run_max_q <= EMPTY_MAX;
            end
            state_q <= B_PIX1;
          end
        end

        // Pixel rows in three steps: scale, divide by constant, centre and clamp.
        B_PIX1: begin
          prod_min_q <= pix_scaled(cmin_q, cfg_i.height);
          prod_max_q <= pix_scaled(cmax_q, cfg_i.height);
          state_q    <= B_PIX2;
        end

        B_PIX2: begin
          off_min_q <= pix_offset(prod_min_q);
          off_max_q <= pix_offset(prod_max_q);
          neg_min_q <= prod_min_q[33];
          neg_max_q <= prod_max_q[33];
          state_q   <= B_PIX3;
        end

        B_PIX3: begin
          if (out_free) begin
            out_valid_q        <= 1'b1;
            out_q.column       <= col_q;
            out_q.column_min   <= cmin_q;
            out_q.column_max   <= cmax_q;
            out_q.top_pixel    <= pix_row(cfg_i.height, off_max_q, neg_max_q);
            out_q.bottom_pixel <= pix_row(cfg_i.height, off_min_q, neg_min_q);
            out_q.last_of_item <= last_q;
            if (last_q) begin
              f_q     <= f_inc[31:0];
              state_q <= B_IDLE;
            end else begin
              state_q <= B_TEST;
            end
          end
        end

        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/waveform_column_peak_envelope.sv
// Column peak envelope for a waveform display.
// Input channel (in_valid_i / in_stall_o / in_data_i): a request with cmd 0
// starts a sweep and clears the column state; cmd 1 carries one Q15 sample in
// frame order. Requests go into a four-entry queue, so the sender is stalled
// only while that queue is full.
// Output channel (out_valid_o / out_stall_i / out_data_o): one item per closed
// column with its min, max, pixel rows and a flag on the last column that a
// sample closes. A sample closes at most 64 columns.
// Config channel (cfg_valid_i / cfg_ready_o): always ready; write only while idle.
// In the back end a sample that closes no column is taken, folded in and
// bound-checked; each column that it closes adds a bound check and the
// three-step pixel unit. A start request is taken and then refills the bounds.
// After reset, or after a write of the frame count or the column count, the
// next start request with a nonzero column count, or sample inside an
// unfinished sweep, first reruns two serial divisions for the column bounds.
// While the receiver stalls, the result holds in the output register; the column
// engine waits before it delivers the next column; queued requests stay in order.
// Reset clears all column state and loads the register defaults.
`default_nettype none

module waveform_column_peak_envelope (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire wcpe_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output wcpe_pkg::out_item_t      out_data_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [31:0]         cfg_data_i
);
  import wcpe_pkg::*;

  logic         q_full;
  logic         q_push;
  logic         q_pop;
  logic         q_empty;
  queue_entry_t q_entry;
  queue_entry_t q_head;
  logic         geo_clear;
  cfg_t         cfg;
  div_req_t     div_req;
  div_rsp_t     div_rsp;

  // Front: request intake and configuration registers.
  wcpe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (q_entry),
    .geo_clear_i (geo_clear),
    .cfg_o       (cfg)
  );

  // Decoupling queue.
  wcpe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .empty_o (q_empty)
  );

  // Serial divider for the column bounds.
  wcpe_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Back: column engine and output register.
  wcpe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .geo_clear_o (geo_clear),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wcpe_pkg::*;

  localparam int unsigned COLUMN_LIMIT     = 4096;
  localparam int unsigned CLOSE_LIMIT      = 64;
  localparam int unsigned SETTLE_CYCLES    = 400;
  localparam int unsigned RANDOM_PER_PHASE = 66;
  localparam int unsigned HOLD_OFF_CYCLES  = 150;
  localparam int unsigned REPORT_LIMIT     = 10;

  localparam logic signed [15:0] Q15_MAX = 16'sh7FFF;
  localparam logic signed [15:0] Q15_MIN = -16'sh8000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  // Idling controls for the sender and the receiver.
  int unsigned idle_pct      = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_off_left = 0;
  int unsigned mismatch_count = 0;
  bit          last_effective;

  // Register copies and column state of the envelope predictor.
  logic [31:0]        span_frames;
  logic [12:0]        span_columns;
  logic [12:0]        span_height;
  int unsigned        cur_column;
  logic [31:0]        frame_pos;
  logic signed [15:0] peak_min;
  logic signed [15:0] peak_max;
  out_item_t          expected_columns[$];

  waveform_column_peak_envelope dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #8_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Column count as the block uses it, limited to the display maximum.
  function automatic int unsigned active_width();
    return (span_columns > COLUMN_LIMIT) ? COLUMN_LIMIT : int'(span_columns);
  endfunction

  function automatic bit sweep_done();
    return cur_column >= active_width();
  endfunction

  // First relative frame of column x.
  function automatic longint unsigned column_start(longint unsigned x, longint unsigned w);
    longint unsigned vf;
    vf = span_frames;
    return (vf * x) / w;
  endfunction

  // End frame (exclusive) of column x; a column always spans at least one frame.
  function automatic longint unsigned column_stop(longint unsigned x, longint unsigned w);
    longint unsigned first;
    longint unsigned stop;
    first = column_start(x, w);
    stop  = column_start(x + 1, w);
    return (stop <= first) ? first + 1 : stop;
  endfunction

  // Screen row of a Q15 value: centre minus the scaled offset, clamped to 12 bits.
  function automatic logic [11:0] screen_row(logic signed [15:0] s);
    longint value;
    longint h;
    longint row;
    value = s;
    h     = span_height;
    row   = (h / 2) - (value * h * 11) / 819200;
    if (row < 0) row = 0;
    if (row > 4095) row = 4095;
    return row[11:0];
  endfunction

  function automatic void clear_peaks();
    peak_min = Q15_MAX;
    peak_max = Q15_MIN;
  endfunction

  function automatic void clear_sweep();
    cur_column = 0;
    frame_pos  = '0;
    clear_peaks();
  endfunction

  // Predicts the columns that one accepted request closes and queues them.
  // Returns 0 when the block ignores the request.
  function automatic bit envelope_predict(in_item_t it);
    int unsigned        w;
    longint unsigned    f;
    int unsigned        n;
    out_item_t          held;
    bit                 have_held;
    logic signed [15:0] s;
    w = active_width();
    if (it.cmd == KIND_START) begin
      clear_sweep();
      return 1'b1;
    end
    if (cur_column >= w) return 1'b0;
    s = it.sample;
    f = frame_pos;
    if (s < peak_min) peak_min = s;
    if (s > peak_max) peak_max = s;
    n = 0;
    have_held = 1'b0;
    held = '0;
    while (n < CLOSE_LIMIT && cur_column < w) begin
      if (f + 1 < column_stop(cur_column, w)) break;
      if (have_held) expected_columns.push_back(held);
      held.column       = 12'(cur_column);
      held.column_min   = peak_min;
      held.column_max   = peak_max;
      held.top_pixel    = screen_row(peak_max);
      held.bottom_pixel = screen_row(peak_min);
      held.last_of_item = 1'b0;
      have_held = 1'b1;
      n++;
      cur_column++;
      clear_peaks();
      // A frame shared with the next column seeds it with this sample.
      if (cur_column < w && column_start(cur_column, w) <= f) begin
        peak_min = s;
        peak_max = s;
      end
    end
    if (have_held) begin
      held.last_of_item = 1'b1;
      expected_columns.push_back(held);
    end
    frame_pos = frame_pos + 32'd1;
    return 1'b1;
  endfunction

  // Compares one delivered column with the oldest expected one.
  function automatic void check_column(out_item_t got);
    out_item_t want;
    if (expected_columns.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("column %0d delivered with nothing expected", got.column);
      return;
    end
    want = expected_columns.pop_front();
    if (got.column !== want.column || got.column_min !== want.column_min ||
        got.column_max !== want.column_max || got.top_pixel !== want.top_pixel ||
        got.bottom_pixel !== want.bottom_pixel ||
        got.last_of_item !== want.last_of_item) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
        $display("mismatch: want col %0d min %0d max %0d top %0d bot %0d last %0b",
                 want.column, want.column_min, want.column_max, want.top_pixel,
                 want.bottom_pixel, want.last_of_item);
        $display("          got  col %0d min %0d max %0d top %0d bot %0d last %0b",
                 got.column, got.column_min, got.column_max, got.top_pixel,
                 got.bottom_pixel, got.last_of_item);
      end
    end
  endfunction

  // Result side: check each accepted column, then choose the next stall.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) check_column(out_data);
    if (hold_off_left != 0) begin
      hold_off_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic set_idling(input int unsigned sender, input int unsigned receiver);
    idle_pct  = sender;
    stall_pct = receiver;
  endtask

  // Offers one request, with random gaps, and predicts it once accepted.
  task automatic send_item(input logic cmd, input logic [15:0] value);
    in_item_t it;
    it.cmd    = cmd;
    it.sample = value;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    last_effective = envelope_predict(it);
  endtask

  task automatic start_sweep();
    send_item(KIND_START, 16'd0);
  endtask

  task automatic feed(input logic [15:0] value);
    send_item(KIND_SAMPLE, value);
  endtask

  // Sender pauses until every expected column has come back.
  task automatic wait_results();
    in_valid <= 1'b0;
    while (expected_columns.size() != 0) @(posedge clk);
  endtask

  // Lets requests that close no column drain from the block as well.
  task automatic settle_block();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    case (idx)
      CFG_VISIBLE_FRAMES: span_frames  = value;
      CFG_COLUMN_COUNT:   span_columns = value[12:0];
      CFG_CANVAS_HEIGHT:  span_height  = value[12:0];
      default: ;
    endcase
  endtask

  // Writes all three registers once the block has gone idle.
  // Bits above the 13-bit registers carry noise that must be dropped.
  task automatic set_config(input logic [31:0] frames, input logic [12:0] cols,
                            input logic [12:0] height);
    settle_block();
    write_reg(CFG_VISIBLE_FRAMES, frames);
    write_reg(CFG_COLUMN_COUNT, {19'($urandom()), cols});
    write_reg(CFG_CANVAS_HEIGHT, {19'($urandom()), height});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(19))
      0:       return Q15_MAX;
      1:       return Q15_MIN;
      2:       return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  // Default registers: a sample without a start request closes nothing.
  task automatic test_reset_state();
    feed(16'h1234);
  endtask

  // One frame per column: each sample closes its own column.
  task automatic test_sample_extremes();
    set_config(32'd64, 13'd64, 13'd256);
    start_sweep();
    feed(Q15_MAX);
    feed(Q15_MIN);
    feed(16'h0000);
    feed(16'h0001);
    feed(16'hFFFF);
    feed(16'h5555);
    feed(16'hAAAA);
  endtask

  // Many columns per frame: more are due than one sample may close.
  task automatic test_shared_frames();
    set_config(32'd16, 13'd4096, 13'd4096);
    start_sweep();
    feed(16'h7000);
    feed(16'h9000);
    feed(16'h0100);
  endtask

  // A short sweep runs out of columns and ignores samples until restarted.
  task automatic test_sweep_end();
    set_config(32'd4, 13'd4, 13'd1);
    start_sweep();
    feed(16'h0010);
    feed(16'hFFF0);
    feed(Q15_MAX);
    feed(Q15_MIN);
    feed(16'h4444);
    start_sweep();
    feed(16'h2222);
  endtask

  // Register extremes: huge frame count, no columns, clamped width and heights.
  task automatic test_register_extremes();
    set_config(32'hFFFF_FFFF, 13'd4096, 13'd4096);
    start_sweep();
    feed(16'h3333);
    set_config(32'd64, 13'd0, 13'd8191);
    feed(16'h0FFF);
    set_config(32'd64, 13'd8191, 13'd0);
    start_sweep();
    feed(16'hC000);
    set_config(32'd64, 13'd64, 13'd8191);
    start_sweep();
    feed(Q15_MAX);
    feed(Q15_MIN);
  endtask

  // The receiver holds off while the sender keeps offering, then the sender
  // pauses until all columns are back.
  task automatic test_backpressure();
    int unsigned i;
    set_config(32'd64, 13'd64, 13'd128);
    set_idling(0, 0);
    start_sweep();
    hold_off_left = HOLD_OFF_CYCLES;
    for (i = 0; i < 16; i++) feed(rand_sample());
    wait_results();
    for (i = 0; i < 8; i++) feed(rand_sample());
  endtask

  // Mostly complete sweeps with random content, plus restarts mid sweep and
  // samples offered after the sweep has finished.
  task automatic test_random_sweeps();
    int unsigned phase;
    int unsigned taken;
    int unsigned frames;
    int unsigned cols;
    bit          restart;
    for (phase = 0; phase < 4; phase++) begin
      frames = $urandom_range(80, 64);
      case ($urandom_range(4))
        0, 1:    cols = $urandom_range(16, 1);
        2, 3:    cols = $urandom_range(frames, 17);
        default: cols = $urandom_range(COLUMN_LIMIT, frames);
      endcase
      set_config(frames, 13'(cols), 13'($urandom_range(4096, 1)));
      case (phase)
        0:       set_idling(0, 0);
        1:       set_idling(49, 0);
        2:       set_idling(0, 49);
        default: set_idling(14, 14);
      endcase
      // Now and then the previous sweep carries over into the new settings.
      if ($urandom_range(3) != 0) start_sweep();
      taken = 0;
      while (taken < RANDOM_PER_PHASE) begin
        if (sweep_done()) restart = ($urandom_range(9) < 7);
        else restart = ($urandom_range(99) < 2);
        if (restart) start_sweep();
        else feed(rand_sample());
        if (last_effective) taken++;
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_VISIBLE_FRAMES;
    cfg_data  = '0;
    span_frames  = VISIBLE_FRAMES_RST;
    span_columns = COLUMN_COUNT_RST;
    span_height  = CANVAS_HEIGHT_RST;
    clear_sweep();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_sample_extremes();
    test_shared_frames();
    test_sweep_end();
    test_register_extremes();
    test_backpressure();
    test_random_sweeps();

    settle_block();
    if (mismatch_count == 0 && expected_columns.size() == 0) begin
      $display("== PASS ==");
    end else begin
      if (expected_columns.size() != 0)
        $display("%0d expected columns never arrived", expected_columns.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: waveform_column_peak_envelope.f
design/wcpe_pkg.sv
design/wcpe_front.sv
design/wcpe_queue.sv
design/wcpe_div.sv
design/wcpe_back.sv
design/waveform_column_peak_envelope.sv
bench/tb_top.sv
